FILE: hdl/crs_pkg.sv
// shared constants and codes for the character range set engine
`default_nettype none
package crs_pkg;
    localparam int MAX_RANGES_DEF = 64;
    localparam int CODE_BITS_DEF  = 21;
    localparam int ACT_BITS       = 3;
    localparam int SLOT_BITS      = 6;
    localparam int STAT_BITS      = 2;
    localparam int CFG_IDX_BITS   = 2;
    localparam int HELD_BITS      = 7;

    localparam logic [ACT_BITS-1:0] ACT_ADD    = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_TEST   = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_NEGATE = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_CLEAR  = 3'd4;
    localparam logic [ACT_BITS-1:0] ACT_READ   = 3'd5;

    localparam logic [STAT_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_NO_IDX  = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNIV_LOW  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNIV_HIGH = 2'd1;
endpackage
`default_nettype wire

FILE: hdl/crs_ram.sv
// generic single write, single registered read ram
`default_nettype none
module crs_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 64
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire  [$clog2(DEPTH)-1:0]     i_waddr,
    input  wire  [WIDTH-1:0]             i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [WIDTH-1:0]             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/char_range_set_engine.sv
// Character range set engine: a class of sorted, disjoint code-point ranges.
// The table lives in two RAM banks; add, delete and negate read the active
// bank one entry at a time (address, then data) and write the new table into
// the other bank, which becomes active when it fits. A split or inserted
// range adds a write state; test scans the same way, read fetches the chosen
// slot, and clear and the other actions need no scan. The next item is
// taken while a result still waits at the output. No clearing pass is
// needed after reset.
`default_nettype none
module char_range_set_engine
    import crs_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int CODE_BITS  = CODE_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [crs_pkg::ACT_BITS-1:0]   i_action,
    input  wire  [CODE_BITS-1:0]           i_range_first,
    input  wire  [CODE_BITS-1:0]           i_range_last,
    input  wire  [crs_pkg::SLOT_BITS-1:0]  i_slot_index,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [crs_pkg::STAT_BITS-1:0]  o_status,
    output logic                           o_covered,
    output logic [CODE_BITS-1:0]           o_found_first,
    output logic [CODE_BITS-1:0]           o_found_last,
    output logic [crs_pkg::HELD_BITS-1:0]  o_ranges_held,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [crs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire  [CODE_BITS-1:0]           i_cfg_data
);
    localparam int W  = CODE_BITS;
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int NW = $clog2(MAX_RANGES + 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_PR   = 3'd2;
    localparam logic [2:0] S_E2   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RS   = 3'd5;
    localparam logic [2:0] S_RC   = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [ACT_BITS-1:0] r_act, n_act;
    logic [W:0]          r_b, n_b, r_e, n_e, r_cur, n_cur;
    logic [W-1:0]        r_lo, r_hi, r_pf, n_pf, r_pl, n_pl;
    logic                r_placed, n_placed;
    logic [CW-1:0]       r_idx, n_idx, r_total, n_total;
    logic [NW-1:0]       r_n, n_n;
    logic                r_bank, n_bank;
    logic [AW-1:0]       r_slot, n_slot;
    logic [STAT_BITS-1:0] r_st, n_st;
    logic                r_cv, n_cv;
    logic [W-1:0]        r_ff, n_ff, r_fl, n_fl;
    logic [W-1:0]        r_ulo, r_uhi;

    logic                w_emit;
    logic [W-1:0]        w_ef, w_el;
    logic [AW-1:0]       w_raddr;
    logic [2*W-1:0]      w_rd0, w_rd1, w_rd;
    logic [W:0]          w_f, w_l;
    logic [CW-1:0]       w_idx1;
    logic [NW-1:0]       w_nfin;
    logic                w_accept;
    logic [W-1:0]        w_ib, w_ie;
    logic [31:0]         w_slot32;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_rd        = r_bank ? w_rd1 : w_rd0;
    assign w_f         = {1'b0, w_rd[2*W-1:W]};
    assign w_l         = {1'b0, w_rd[W-1:0]};
    assign w_idx1      = r_idx + 1'b1;
    assign w_raddr     = (r_state == S_RD) ? r_idx[AW-1:0] : r_slot;
    assign w_ib = (i_range_first > i_range_last) ? i_range_last : i_range_first;
    assign w_ie = (i_range_first > i_range_last) ? i_range_first : i_range_last;
    assign w_slot32 = 32'(i_slot_index);

    crs_ram #(.WIDTH(2*W), .DEPTH(MAX_RANGES)) u_bank0 (
        .i_clk(i_clk), .i_we(w_emit && r_bank && (r_n < NW'(MAX_RANGES))),
        .i_waddr(r_n[AW-1:0]), .i_wdata({w_ef, w_el}),
        .i_raddr(w_raddr), .o_rdata(w_rd0)
    );
    crs_ram #(.WIDTH(2*W), .DEPTH(MAX_RANGES)) u_bank1 (
        .i_clk(i_clk), .i_we(w_emit && !r_bank && (r_n < NW'(MAX_RANGES))),
        .i_waddr(r_n[AW-1:0]), .i_wdata({w_ef, w_el}),
        .i_raddr(w_raddr), .o_rdata(w_rd1)
    );

    assign w_nfin = r_n + NW'(w_emit);

    always_comb begin
        n_state = r_state; n_act = r_act; n_b = r_b; n_e = r_e; n_cur = r_cur;
        n_pf = r_pf; n_pl = r_pl; n_placed = r_placed; n_idx = r_idx;
        n_total = r_total; n_n = r_n; n_bank = r_bank; n_slot = r_slot;
        n_st = r_st; n_cv = r_cv; n_ff = r_ff; n_fl = r_fl;
        w_emit = 1'b0; w_ef = '0; w_el = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_act = i_action; n_st = ST_OK; n_cv = 1'b0;
                    n_ff = '0; n_fl = '0; n_placed = 1'b0; n_n = '0;
                    n_idx = '0; n_cur = {1'b0, r_lo};
                    n_slot = w_slot32[AW-1:0];
                    n_b = {1'b0, w_ib}; n_e = {1'b0, w_ie};
                    n_state = (r_total == '0) ? S_FIN : S_RD;
                    priority case (i_action)
                        ACT_ADD: begin
                            if (w_ib > r_hi || w_ie < r_lo) begin
                                n_st = ST_OUTSIDE; n_state = S_DONE;
                            end else begin
                                if (w_ib < r_lo) n_b = {1'b0, r_lo};
                                if (w_ie > r_hi) n_e = {1'b0, r_hi};
                            end
                        end
                        ACT_DELETE, ACT_TEST, ACT_NEGATE: ;
                        ACT_CLEAR: begin
                            n_total = '0; n_state = S_DONE;
                        end
                        ACT_READ: begin
                            if (w_slot32 < 32'(r_total)) begin
                                n_state = S_RS;
                            end else begin
                                n_st = ST_NO_IDX; n_state = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RD: n_state = S_PR;
            S_PR: begin
                n_state = (w_idx1 == r_total) ? S_FIN : S_RD;
                n_idx = w_idx1;
                priority case (r_act)
                    ACT_ADD: begin
                        if (w_l + 1'b1 < r_b) begin
                            w_emit = 1'b1; w_ef = w_f[W-1:0]; w_el = w_l[W-1:0];
                        end else if (w_f > r_e + 1'b1) begin
                            w_emit = 1'b1;
                            if (!r_placed) begin
                                // new range goes first, stored one follows
                                w_ef = r_b[W-1:0]; w_el = r_e[W-1:0];
                                n_placed = 1'b1;
                                n_pf = w_f[W-1:0]; n_pl = w_l[W-1:0];
                                n_state = S_E2;
                            end else begin
                                w_ef = w_f[W-1:0]; w_el = w_l[W-1:0];
                            end
                        end else begin
                            if (w_f < r_b) n_b = w_f;
                            if (w_l > r_e) n_e = w_l;
                        end
                    end
                    ACT_DELETE: begin
                        if (w_l < r_b || w_f > r_e) begin
                            w_emit = 1'b1; w_ef = w_f[W-1:0]; w_el = w_l[W-1:0];
                        end else if (w_f < r_b) begin
                            w_emit = 1'b1; w_ef = w_f[W-1:0];
                            w_el = W'(r_b - 1'b1);
                            if (w_l > r_e) begin
                                n_pf = W'(r_e + 1'b1); n_pl = w_l[W-1:0];
                                n_state = S_E2;
                            end
                        end else if (w_l > r_e) begin
                            w_emit = 1'b1; w_ef = W'(r_e + 1'b1); w_el = w_l[W-1:0];
                        end
                    end
                    ACT_TEST: begin
                        if (r_b >= w_f && r_e <= w_l) n_cv = 1'b1;
                    end
                    ACT_NEGATE: begin
                        if (w_l >= r_cur) begin
                            if (w_f > r_cur && r_cur <= {1'b0, r_hi}) begin
                                w_emit = 1'b1; w_ef = r_cur[W-1:0];
                                w_el = (w_f - 1'b1 > {1'b0, r_hi}) ? r_hi
                                                                   : W'(w_f - 1'b1);
                            end
                            n_cur = w_l + 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (w_emit) n_n = r_n + 1'b1;
            end
            S_E2: begin
                w_emit = 1'b1; w_ef = r_pf; w_el = r_pl;
                n_n = r_n + 1'b1;
                n_state = (r_idx == r_total) ? S_FIN : S_RD;
            end
            S_FIN: begin
                n_state = S_DONE;
                if (r_act == ACT_ADD && !r_placed) begin
                    w_emit = 1'b1; w_ef = r_b[W-1:0]; w_el = r_e[W-1:0];
                end else if (r_act == ACT_NEGATE && r_cur <= {1'b0, r_hi}) begin
                    w_emit = 1'b1; w_ef = r_cur[W-1:0]; w_el = r_hi;
                end
                if (r_act != ACT_TEST) begin
                    if (w_nfin > NW'(MAX_RANGES)) begin
                        n_st = ST_FULL;
                    end else begin
                        n_total = CW'(w_nfin);
                        n_bank = !r_bank;
                    end
                end
            end
            S_RS: n_state = S_RC;
            S_RC: begin
                n_ff = w_rd[2*W-1:W]; n_fl = w_rd[W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!o_out_valid || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // universe bounds kept in ascending order
    assign r_lo = (r_ulo > r_uhi) ? r_uhi : r_ulo;
    assign r_hi = (r_ulo > r_uhi) ? r_ulo : r_uhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_total <= '0; r_bank <= 1'b0;
            r_ulo <= '0; r_uhi <= W'(1114111); o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_total <= n_total; r_bank <= n_bank;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_UNIV_LOW)  r_ulo <= i_cfg_data;
                if (i_cfg_index == REG_UNIV_HIGH) r_uhi <= i_cfg_data;
            end
            if (r_state == S_DONE && (!o_out_valid || !i_out_stall)) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act; r_b <= n_b; r_e <= n_e; r_cur <= n_cur;
        r_pf <= n_pf; r_pl <= n_pl; r_placed <= n_placed; r_idx <= n_idx;
        r_n <= n_n; r_slot <= n_slot; r_st <= n_st; r_cv <= n_cv;
        r_ff <= n_ff; r_fl <= n_fl;
        if (r_state == S_DONE && (!o_out_valid || !i_out_stall)) begin
            o_status <= r_st; o_covered <= r_cv;
            o_found_first <= r_ff; o_found_last <= r_fl;
            o_ranges_held <= HELD_BITS'(r_total);
        end
    end
endmodule
`default_nettype wire
